[rtl/mofn_pkg.sv]
// Package for the M-of-N detection confirm filter: word types, sizes,
// register indexes, controller states and the controller/datapath command bundles.
// Depends on nothing.
package mofn_pkg;

  localparam int unsigned WINDOW_MAX   = 16;
  localparam int unsigned SLOT_BITS    = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_BITS     = SLOT_BITS + 1;
  localparam int unsigned COORD_BITS   = 24;
  localparam int unsigned EXTENT_BITS  = 23;
  localparam int unsigned CFG_BITS     = 5;
  localparam int unsigned SUM_BITS     = COORD_BITS + SLOT_BITS;
  localparam int unsigned DIV_STEPS    = SUM_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(DIV_STEPS);

  // 0.01 m in units of 1/65536 m, truncated.
  localparam logic [EXTENT_BITS-1:0] SIZE_FLOOR = EXTENT_BITS'(655);

  // Register indexes, taken from address bit 2.
  localparam logic REG_WINDOW_LENGTH = 1'b0;
  localparam logic REG_NEEDED_COUNT  = 1'b1;

  typedef struct packed {
    logic                          detected;
    logic signed [COORD_BITS-1:0]  pos_x;
    logic signed [COORD_BITS-1:0]  pos_y;
    logic signed [COORD_BITS-1:0]  pos_z;
    logic        [EXTENT_BITS-1:0] extent_x;
    logic        [EXTENT_BITS-1:0] extent_y;
    logic        [EXTENT_BITS-1:0] extent_z;
  } in_word_t;

  typedef struct packed {
    logic                          marker_delete;
    logic signed [COORD_BITS-1:0]  mean_x;
    logic signed [COORD_BITS-1:0]  mean_y;
    logic signed [COORD_BITS-1:0]  mean_z;
    logic        [EXTENT_BITS-1:0] box_x;
    logic        [EXTENT_BITS-1:0] box_y;
    logic        [EXTENT_BITS-1:0] box_z;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIVIDE,
    ST_ADD_OUT,
    ST_DEL_OUT
  } mofn_state_e;

  typedef struct packed {
    logic in_ready;
    logic store;
    logic scan_step;
    logic div_start;
    logic div_step;
    logic load_out;
    logic out_delete;
  } mofn_cmd_t;

  typedef struct packed {
    logic item_det;
    logic scan_done;
    logic hits_ok;
    logic hits_zero;
    logic div_last;
    logic out_busy;
  } mofn_status_t;

endpackage

[rtl/mofn_ctrl.sv]
// Controller state machine of the M-of-N detection confirm filter.
// Depends on mofn_pkg; drives the datapath by mofn_cmd_t and reads mofn_status_t.
module mofn_ctrl
  import mofn_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  mofn_status_t status_i,
  output mofn_cmd_t    cmd_o
);

  mofn_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.item_det) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_done) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!status_i.hits_ok) begin
          state_d = ST_DEL_OUT;
        end else if (status_i.hits_zero) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          state_d = ST_ADD_OUT;
        end
      end
      ST_ADD_OUT, ST_DEL_OUT: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.store    = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan_step = !status_i.scan_done;
      end
      ST_DECIDE: begin
        cmd_o.div_start = status_i.hits_ok && !status_i.hits_zero;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_ADD_OUT: begin
        cmd_o.load_out = !status_i.out_busy;
      end
      ST_DEL_OUT: begin
        cmd_o.load_out   = !status_i.out_busy;
        cmd_o.out_delete = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[rtl/mofn_datapath.sv]
// Datapath of the M-of-N detection confirm filter: frame ring, window scan,
// three-lane restoring divider and output register. Depends on mofn_pkg.
module mofn_datapath
  import mofn_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mofn_cmd_t           cmd_i,
  input  logic [CFG_BITS-1:0] window_length_i,
  input  logic [CFG_BITS-1:0] needed_count_i,
  input  in_word_t            in_word_i,
  output mofn_status_t        status_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_word_o
);

  logic                         hit_q [WINDOW_MAX];
  logic signed [COORD_BITS-1:0] ring_x_q [WINDOW_MAX];
  logic signed [COORD_BITS-1:0] ring_y_q [WINDOW_MAX];
  logic signed [COORD_BITS-1:0] ring_z_q [WINDOW_MAX];

  logic [SLOT_BITS-1:0]    slot_q, cur_slot_q;
  logic [CNT_BITS-1:0]     fill_q, fill_d, span_q, span_d, wl_cap, k_q, hits_q;
  logic [SLOT_BITS-1:0]    rd_idx;
  logic [EXTENT_BITS-1:0]  ext_x_q, ext_y_q, ext_z_q;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;

  logic signed [SUM_BITS-1:0]   acc_q [3];
  logic        [SUM_BITS-1:0]   quo_q [3];
  logic        [SLOT_BITS-1:0]  rem_q [3];
  logic                         sgn_q [3];
  logic signed [COORD_BITS-1:0] rd_val [3];
  logic        [SLOT_BITS:0]    rem_shift [3];
  logic        [COORD_BITS-1:0] mean [3];

  logic      out_valid_q;
  out_word_t out_word_q;

  // Span of the vote: newest min(window_length, WINDOW_MAX, fill) entries.
  always_comb begin
    fill_d = (fill_q < CNT_BITS'(WINDOW_MAX)) ? fill_q + 1'b1 : fill_q;
    wl_cap = (window_length_i > CNT_BITS'(WINDOW_MAX)) ? CNT_BITS'(WINDOW_MAX)
                                                        : window_length_i;
    span_d = (wl_cap < fill_d) ? wl_cap : fill_d;
  end

  assign rd_idx    = cur_slot_q - k_q[SLOT_BITS-1:0];
  assign rd_val[0] = ring_x_q[rd_idx];
  assign rd_val[1] = ring_y_q[rd_idx];
  assign rd_val[2] = ring_z_q[rd_idx];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_shift[l] = {rem_q[l], quo_q[l][SUM_BITS-1]};
      mean[l]      = sgn_q[l] ? -quo_q[l][COORD_BITS-1:0] : quo_q[l][COORD_BITS-1:0];
    end
  end

  // Hit flags reset clear, which empties the ring; coordinates need no reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        hit_q[i] <= 1'b0;
      end
      slot_q <= '0;
      fill_q <= '0;
    end else if (cmd_i.store) begin
      hit_q[slot_q] <= in_word_i.detected;
      slot_q        <= slot_q + 1'b1;
      fill_q        <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      ring_x_q[slot_q] <= in_word_i.pos_x;
      ring_y_q[slot_q] <= in_word_i.pos_y;
      ring_z_q[slot_q] <= in_word_i.pos_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      hits_q    <= '0;
      span_q    <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.store) begin
        k_q    <= '0;
        hits_q <= '0;
        span_q <= span_d;
      end else if (cmd_i.scan_step) begin
        k_q <= k_q + 1'b1;
        if (hit_q[rd_idx]) begin
          hits_q <= hits_q + 1'b1;
        end
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      cur_slot_q <= slot_q;
      ext_x_q    <= in_word_i.extent_x;
      ext_y_q    <= in_word_i.extent_y;
      ext_z_q    <= in_word_i.extent_z;
    end
    for (int l = 0; l < 3; l++) begin
      if (cmd_i.store) begin
        acc_q[l] <= '0;
      end else if (cmd_i.scan_step && hit_q[rd_idx]) begin
        acc_q[l] <= acc_q[l] + SUM_BITS'(rd_val[l]);
      end
      if (cmd_i.div_start) begin
        sgn_q[l] <= acc_q[l][SUM_BITS-1];
        quo_q[l] <= acc_q[l][SUM_BITS-1] ? -acc_q[l] : acc_q[l];
        rem_q[l] <= '0;
      end else if (cmd_i.div_step) begin
        if (rem_shift[l] >= hits_q) begin
          rem_q[l] <= SLOT_BITS'(rem_shift[l] - hits_q);
          quo_q[l] <= {quo_q[l][SUM_BITS-2:0], 1'b1};
        end else begin
          rem_q[l] <= rem_shift[l][SLOT_BITS-1:0];
          quo_q[l] <= {quo_q[l][SUM_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (cmd_i.out_delete) begin
        out_word_q <= {1'b1, {($bits(out_word_t)-1){1'b0}}};
      end else begin
        out_word_q.marker_delete <= 1'b0;
        out_word_q.mean_x        <= mean[0];
        out_word_q.mean_y        <= mean[1];
        out_word_q.mean_z        <= mean[2];
        out_word_q.box_x         <= (ext_x_q < SIZE_FLOOR) ? SIZE_FLOOR : ext_x_q;
        out_word_q.box_y         <= (ext_y_q < SIZE_FLOOR) ? SIZE_FLOOR : ext_y_q;
        out_word_q.box_z         <= (ext_z_q < SIZE_FLOOR) ? SIZE_FLOOR : ext_z_q;
      end
    end
  end

  always_comb begin
    status_o.item_det  = in_word_i.detected;
    status_o.scan_done = (k_q == span_q);
    status_o.hits_ok   = (hits_q >= needed_count_i);
    status_o.hits_zero = (hits_q == '0);
    status_o.div_last  = (div_cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1));
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[rtl/m_of_n_detection_confirm_filter.sv]
// M-of-N detection confirm filter: a missed frame leaves it in idle. A detected frame is
// scanned one window entry per cycle; a confirmed word is loaded after the scan and the
// 28-step divider, a withdrawn word after the scan, and a frame that gives no word is back
// in idle after decide; a load waits while the output is busy. The next word is accepted in
// the cycle after the result is loaded, even while it waits. Reset (asynchronous, active low)
// clears the hit flags, sets window_length 5 and needed_count 3. Uses mofn_pkg, ctrl, datapath.
module m_of_n_detection_confirm_filter
  import mofn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_word_t   out_word_o
);

  logic [CFG_BITS-1:0] window_length_q, needed_count_q;
  logic                cfg_write;
  mofn_cmd_t           cmd;
  mofn_status_t        status;

  // The APB port never stalls. Address bit 2 picks the register; the two
  // low address bits are not decoded, so every address maps to a register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= CFG_BITS'(5);
      needed_count_q  <= CFG_BITS'(3);
    end else if (cfg_write) begin
      if (paddr[2] == REG_WINDOW_LENGTH) begin
        window_length_q <= pwdata[CFG_BITS-1:0];
      end else begin
        needed_count_q <= pwdata[CFG_BITS-1:0];
      end
    end
  end

  // Reads return the register value, zero extended.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NEEDED_COUNT) begin
      prdata[CFG_BITS-1:0] = needed_count_q;
    end else begin
      prdata[CFG_BITS-1:0] = window_length_q;
    end
  end

  // The controller sequences store, scan, decide, divide and result load.
  mofn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the ring, the accumulators, the divider lanes and the
  // output register that parts the input side from the output side.
  mofn_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .window_length_i (window_length_q),
    .needed_count_i  (needed_count_q),
    .in_word_i       (in_word_i),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_word_o      (out_word_o)
  );

  assign in_ready_o = cmd.in_ready;

endmodule
